// ===== rtl/core/sha_pkg.sv =====
// Shared constants, types and a rotate function for the SHA-256 stream hasher.
package sha_pkg;

   localparam int WordWidth = 32;
   localparam int BlockWords = 16;
   localparam int HashWords = 8;
   localparam int Rounds = 64;
   localparam int LenWidth = 64;

   localparam logic [31:0] HASH_IV [HashWords] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [Rounds] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // Word source selected by the controller when loading the block buffer
   typedef enum logic [2:0] {
      SRC_DATA,
      SRC_PAD_LAST,
      SRC_PAD80,
      SRC_ZERO,
      SRC_LEN_HI,
      SRC_LEN_LO
   } word_src_type;

   typedef struct packed {
      logic         push;       // write one word into the block buffer
      word_src_type src;
      logic         add_full;   // bit count += 32
      logic         add_last;   // bit count += 8 * valid bytes
      logic         comp_start; // load working words from hash
      logic         round_en;   // run one round
      logic         comp_end;   // fold working words into hash
      logic         clear;      // back to initial vector, zero count
   } dp_cmd_type;

   typedef struct packed {
      logic [3:0] fill;
      logic [5:0] round;
   } dp_status_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

// ===== rtl/core/sha_datapath.sv =====
// Block buffer, message schedule, round logic and hash state.
module sha_datapath import sha_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   input  logic [31:0]         data_word,
   input  logic [2:0]          valid_bytes,
   input  logic [2:0]          out_sel,
   output dp_status_type       status,
   output logic [31:0]         digest_word
);

   logic [31:0] block_ff [BlockWords];
   logic [31:0] work_ff  [HashWords];
   logic [31:0] hash_ff  [HashWords];
   logic [LenWidth-1:0] count_ff, count_in;
   logic [3:0]  fill_ff, fill_in;
   logic [5:0]  round_ff, round_in;

   logic [2:0]  vb;
   logic [31:0] keep, pad_word, push_word;
   logic [31:0] w2, w15, s0, s1, w_new, w_t;
   logic [31:0] t1, t2, ch, maj, e_sig, a_sig;
   logic [3:0]  ti;

   assign vb = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;

   always_comb begin
      case (vb)
         3'd0:    keep = 32'h00000000;
         3'd1:    keep = 32'hff000000;
         3'd2:    keep = 32'hffff0000;
         3'd3:    keep = 32'hffffff00;
         default: keep = 32'hffffffff;
      endcase
      pad_word = (data_word & keep) | (32'h80000000 >> {vb, 3'b000});
   end

   always_comb begin
      case (cmd.src)
         SRC_DATA:     push_word = data_word;
         SRC_PAD_LAST: push_word = pad_word;
         SRC_PAD80:    push_word = 32'h80000000;
         SRC_LEN_HI:   push_word = count_ff[63:32];
         SRC_LEN_LO:   push_word = count_ff[31:0];
         default:      push_word = '0;
      endcase
   end

   // rolling 16-word schedule
   assign ti    = round_ff[3:0];
   assign w2    = block_ff[4'(ti - 4'd2)];
   assign w15   = block_ff[4'(ti - 4'd15)];
   assign s1    = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
   assign s0    = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
   assign w_new = s1 + block_ff[4'(ti - 4'd7)] + s0 + block_ff[ti];
   assign w_t   = (round_ff < 6'd16) ? block_ff[ti] : w_new;

   assign e_sig = rotr(work_ff[4], 6) ^ rotr(work_ff[4], 11) ^ rotr(work_ff[4], 25);
   assign a_sig = rotr(work_ff[0], 2) ^ rotr(work_ff[0], 13) ^ rotr(work_ff[0], 22);
   assign ch    = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
   assign maj   = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
                ^ (work_ff[1] & work_ff[2]);
   assign t1    = work_ff[7] + e_sig + ch + ROUND_K[round_ff] + w_t;
   assign t2    = a_sig + maj;

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) count_in = '0;
      else if (cmd.add_full) count_in = count_ff + 64'd32;
      else if (cmd.add_last) count_in = count_ff + {58'd0, vb, 3'b000};
      fill_in  = cmd.push ? 4'(fill_ff + 4'd1) : fill_ff;
      if (cmd.clear) fill_in = '0;
      round_in = cmd.round_en ? 6'(round_ff + 6'd1) : round_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         fill_ff  <= '0;
         round_ff <= '0;
         for (int i = 0; i < HashWords; i++) hash_ff[i] <= HASH_IV[i];
      end else begin
         count_ff <= count_in;
         fill_ff  <= fill_in;
         round_ff <= round_in;
         if (cmd.clear) begin
            for (int i = 0; i < HashWords; i++) hash_ff[i] <= HASH_IV[i];
         end else if (cmd.comp_end) begin
            for (int i = 0; i < HashWords; i++) hash_ff[i] <= hash_ff[i] + work_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) block_ff[fill_ff] <= push_word;
      else if (cmd.round_en && round_ff >= 6'd16) block_ff[ti] <= w_new;
      if (cmd.comp_start) begin
         for (int i = 0; i < HashWords; i++) work_ff[i] <= hash_ff[i];
      end else if (cmd.round_en) begin
         work_ff[7] <= work_ff[6];
         work_ff[6] <= work_ff[5];
         work_ff[5] <= work_ff[4];
         work_ff[4] <= work_ff[3] + t1;
         work_ff[3] <= work_ff[2];
         work_ff[2] <= work_ff[1];
         work_ff[1] <= work_ff[0];
         work_ff[0] <= t1 + t2;
      end
   end

   assign status.fill  = fill_ff;
   assign status.round = round_ff;
   assign digest_word  = hash_ff[out_sel];

endmodule

// ===== rtl/core/sha_control.sv =====
// Controller: accepts requests, sequences padding, compression and digest output.
module sha_control import sha_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [2:0]    valid_bytes,
   input  logic          last_item,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [2:0]    out_sel
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_COMP_INIT, ST_ROUND, ST_COMP_END,
      ST_PAD80, ST_ZERO, ST_LEN_HI, ST_LEN_LO, ST_OUT, ST_CLEAR
   } state_type;

   state_type   state_ff, state_in;
   logic        final_ff, final_in;   // compression belongs to padding tail
   logic [2:0]  sel_ff, sel_in;
   logic        accept;
   // padding still open when a block fills mid-padding
   logic        pad_pending_ff, pad_pending_in;
   logic        pad80_due_ff, pad80_due_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_OUT);
   assign out_sel   = sel_ff;

   always_comb begin
      state_in = state_ff;
      final_in = final_ff;
      sel_in   = sel_ff;
      cmd      = '0;
      cmd.src  = SRC_DATA;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.push = 1'b1;
               if (!last_item) begin
                  cmd.add_full = 1'b1;
                  final_in = 1'b0;
               end else begin
                  cmd.add_last = 1'b1;
                  final_in = 1'b1;
                  cmd.src = (valid_bytes >= 3'd4) ? SRC_DATA : SRC_PAD_LAST;
               end
               if (status.fill == 4'd15) state_in = ST_COMP_INIT;
               else if (last_item) state_in = (valid_bytes >= 3'd4) ? ST_PAD80 : ST_ZERO;
            end
         end
         ST_PAD80: begin
            cmd.push = 1'b1;
            cmd.src  = SRC_PAD80;
            state_in = (status.fill == 4'd15) ? ST_COMP_INIT : ST_ZERO;
         end
         ST_ZERO: begin
            if (status.fill == 4'd14) state_in = ST_LEN_HI;
            else begin
               cmd.push = 1'b1;
               cmd.src  = SRC_ZERO;
               if (status.fill == 4'd15) state_in = ST_COMP_INIT;
            end
         end
         ST_LEN_HI: begin
            cmd.push = 1'b1;
            cmd.src  = SRC_LEN_HI;
            state_in = ST_LEN_LO;
         end
         ST_LEN_LO: begin
            cmd.push = 1'b1;
            cmd.src  = SRC_LEN_LO;
            sel_in   = '0;
            state_in = ST_COMP_INIT;
         end
         ST_COMP_INIT: begin
            cmd.comp_start = 1'b1;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            if (status.round == 6'd63) state_in = ST_COMP_END;
         end
         ST_COMP_END: begin
            cmd.comp_end = 1'b1;
            sel_in = '0;
            if (!final_ff) state_in = ST_IDLE;
            else if (pad_pending_ff) state_in = pad80_due_ff ? ST_PAD80 : ST_ZERO;
            else state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               sel_in = 3'(sel_ff + 3'd1);
               if (sel_ff == 3'd7) state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pad_pending_in = pad_pending_ff;
      pad80_due_in   = pad80_due_ff;
      if (accept && last_item) begin
         pad_pending_in = 1'b1;
         pad80_due_in   = (valid_bytes >= 3'd4);
      end
      if (state_ff == ST_PAD80) pad80_due_in = 1'b0;
      if (state_ff == ST_LEN_LO) pad_pending_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         final_ff       <= 1'b0;
         sel_ff         <= '0;
         pad_pending_ff <= 1'b0;
         pad80_due_ff   <= 1'b0;
      end else begin
         pad_pending_ff <= pad_pending_in;
         pad80_due_ff   <= pad80_due_in;
         sel_ff         <= sel_in;
         final_ff       <= final_in;
         state_ff       <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_no_req_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready) else $error("ready while busy");
   a_rounds_from_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMP_INIT) |-> (status.round == 6'd0))
      else $error("round counter not at zero");
   a_out_sel_start: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> (out_sel == 3'd0)) else $error("digest not from word 0");
   a_clear_after_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && out_sel == 3'd7) |=> (state_ff == ST_CLEAR))
      else $error("no clear after digest");
`endif

endmodule

// ===== rtl/core/sha256_stream_hasher.sv =====
// SHA-256 stream hasher: takes one 32-bit message word per request and,
// on the last word, pads the message and returns the eight digest words.
// A word that fills the 16-word block is followed by a compression (load,
// 64 rounds one per cycle in the shared round unit, fold). A last word adds
// the padding (0x80 marker, zero words, 64-bit length), one or two
// compressions, the eight result words (rsp_ready can stall them) and a
// reload of the initial hash. req_ready is low while padding, while a block
// compresses and while a digest is emitted.
module sha256_stream_hasher import sha_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_valid_bytes,
   input  logic        req_last_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [2:0]    out_sel;

   sha_control u_control (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .valid_bytes (req_valid_bytes),
      .last_item   (req_last_item),
      .status      (status),
      .cmd         (cmd),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .out_sel     (out_sel)
   );

   sha_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_word   (req_data_word),
      .valid_bytes (req_valid_bytes),
      .out_sel     (out_sel),
      .status      (status),
      .digest_word (rsp_digest_word)
   );

   assign rsp_word_index = out_sel;
   assign rsp_last_word  = (out_sel == 3'd7);

endmodule
